// ===== design/pmd_pkg.sv =====
// shared types, widths and register codes for the pointer motion detector
package pmd_pkg;

    // fixed field widths
    localparam int POS_FIELD_W = 14;
    localparam int METRIC_W    = 23;
    localparam int THR_W       = 15;
    localparam int WEIGHT_W    = 9;

    // parameter defaults
    localparam int POS_BITS_DEF  = 14;
    localparam int FRAC_BITS_DEF = 8;

    // smoothing arithmetic
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 9'd256;
    localparam int                  WEIGHT_SHIFT = 8;
    localparam logic [METRIC_W-1:0] METRIC_MAX   = {METRIC_W{1'b1}};

    // configuration registers
    localparam int                  PADDR_W      = 3;
    localparam int                  PDATA_W      = 32;
    localparam int                  REG_IDX_LSB  = 2;
    localparam logic                REG_IDX_THR  = 1'b0;
    localparam logic                REG_IDX_WGT  = 1'b1;
    localparam logic [THR_W-1:0]    THR_RESET    = 15'd90;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd205;

    typedef struct packed {
        logic [POS_FIELD_W-1:0] pos_x;
        logic [POS_FIELD_W-1:0] pos_y;
    } t_in_item;

    typedef struct packed {
        logic [METRIC_W-1:0] smoothed_metric;
        logic                large_motion;
    } t_out_item;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

// ===== design/pmd_smac.sv =====
// bit-serial sum of two products, multiplier bits taken msb first
module pmd_smac #(
    parameter int OPD_W = 14,
    parameter int MUL_W = 14
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [OPD_W-1:0]         i_opd_a,
    input  logic [OPD_W-1:0]         i_opd_b,
    input  logic [MUL_W-1:0]         i_mul_a,
    input  logic [MUL_W-1:0]         i_mul_b,
    output logic [OPD_W+MUL_W:0]     o_acc,
    output pmd_pkg::t_unit_sts       o_sts
);

    localparam int ACC_W = OPD_W + MUL_W + 1;
    localparam int CNT_W = $clog2(MUL_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [ACC_W-1:0] r_acc;
    logic [OPD_W-1:0] r_a;
    logic [OPD_W-1:0] r_b;
    logic [MUL_W-1:0] r_ma;
    logic [MUL_W-1:0] r_mb;

    logic [ACC_W-1:0] w_pa;
    logic [ACC_W-1:0] w_pb;
    logic [ACC_W-1:0] n_acc;

    assign w_pa  = r_ma[MUL_W-1] ? ACC_W'(r_a) : '0;
    assign w_pb  = r_mb[MUL_W-1] ? ACC_W'(r_b) : '0;
    assign n_acc = {r_acc[ACC_W-2:0], 1'b0} + w_pa + w_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(MUL_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_opd_a;
            r_b   <= i_opd_b;
            r_ma  <= i_mul_a;
            r_mb  <= i_mul_b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_ma  <= {r_ma[MUL_W-2:0], 1'b0};
            r_mb  <= {r_mb[MUL_W-2:0], 1'b0};
        end
    end

    assign o_acc      = r_acc;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

// ===== design/pmd_sqrt.sv =====
// floor square root, one root bit per cycle, radicand shifted in two bits a step
module pmd_sqrt #(
    parameter int ROOT_W = 23
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [2*ROOT_W-1:0]     i_radicand,
    output logic [ROOT_W-1:0]       o_root,
    output pmd_pkg::t_unit_sts      o_sts
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int CNT_W = $clog2(ROOT_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W-1:0] r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [ROOT_W+1:0] w_rem_sh;
    logic [ROOT_W+1:0] w_trial;
    logic [ROOT_W+2:0] w_diff;
    logic              w_ge;

    // partial remainder stays below 2^ROOT_W until the last step
    assign w_rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_diff   = {1'b0, w_rem_sh} - {1'b0, w_trial};
    assign w_ge     = ~w_diff[ROOT_W+2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(ROOT_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[ROOT_W-1:0] : w_rem_sh[ROOT_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], w_ge};
        end
    end

    assign o_root     = r_root;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

// ===== design/pointer_motion_ema_detector.sv =====
// pointer motion detector: step length by serial square root, smoothed and thresholded
// One position per transaction, taken only while the block is idle; the next position
// is accepted on the cycle after the result register is loaded. Three serial units run
// one after another: the sum of squares of the step (POS_BITS multiplier bits, one at a
// time), the square root (POS_BITS + FRAC_BITS + 1 root bits, one at a time) and the
// weighted average (9 weight bits, one at a time). The result register holds a finished
// result while the next position is taken; if it is still stalled when the next result
// is ready, the block waits. The length carries FRAC_BITS fraction bits, the smoothed
// metric saturates at its 23-bit maximum, a weight above 256 acts as 256, and the stored
// previous position and metric start at zero. Registers: motion threshold at byte
// address 0, smoothing weight at byte address 4.
module pointer_motion_ema_detector #(
    parameter int POS_BITS  = pmd_pkg::POS_BITS_DEF,
    parameter int FRAC_BITS = pmd_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  pmd_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pmd_pkg::t_out_item            o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pmd_pkg::PADDR_W-1:0]   paddr,
    input  logic [pmd_pkg::PDATA_W-1:0]   pwdata,
    output logic [pmd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int SUM_W     = 2 * POS_BITS + 1;
    localparam int ROOT_W    = POS_BITS + FRAC_BITS + 1;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int EMA_OPD_W = (ROOT_W > pmd_pkg::METRIC_W) ? ROOT_W : pmd_pkg::METRIC_W;
    localparam int EMA_ACC_W = EMA_OPD_W + pmd_pkg::WEIGHT_W + 1;
    localparam int SAT_LSB   = pmd_pkg::WEIGHT_SHIFT + pmd_pkg::METRIC_W;
    localparam int CMP_W     = (pmd_pkg::THR_W + FRAC_BITS > pmd_pkg::METRIC_W)
                             ? pmd_pkg::THR_W + FRAC_BITS : pmd_pkg::METRIC_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SQR  = 4'b0010,
        S_ROOT = 4'b0100,
        S_EMA  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [pmd_pkg::THR_W-1:0]    r_thr;
    logic [pmd_pkg::WEIGHT_W-1:0] r_weight;
    logic [POS_BITS-1:0]          r_prev_x;
    logic [POS_BITS-1:0]          r_prev_y;
    logic [pmd_pkg::METRIC_W-1:0] r_metric;
    logic                         r_out_valid;
    pmd_pkg::t_out_item           r_out_data;

    logic                         w_cfg_wr;
    logic                         w_in_acc;
    logic                         w_out_free;
    logic                         w_root_start;
    logic                         w_ema_start;
    logic                         w_out_load;
    logic [POS_BITS-1:0]          w_x;
    logic [POS_BITS-1:0]          w_y;
    logic [POS_BITS-1:0]          w_dx;
    logic [POS_BITS-1:0]          w_dy;
    logic [SUM_W-1:0]             w_sum;
    logic [RAD_W-1:0]             w_rad;
    logic [ROOT_W-1:0]            w_root;
    logic [pmd_pkg::WEIGHT_W-1:0] w_alpha;
    logic [pmd_pkg::WEIGHT_W-1:0] w_beta;
    logic [EMA_ACC_W-1:0]         w_ema_acc;
    logic [pmd_pkg::METRIC_W-1:0] w_metric;
    logic [CMP_W-1:0]             w_thr_cmp;
    logic                         w_flag;

    pmd_pkg::t_unit_sts           sqr_sts;
    pmd_pkg::t_unit_sts           root_sts;
    pmd_pkg::t_unit_sts           ema_sts;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= pmd_pkg::THR_RESET;
            r_weight <= pmd_pkg::WEIGHT_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[pmd_pkg::REG_IDX_LSB])
                pmd_pkg::REG_IDX_THR: r_thr    <= pwdata[pmd_pkg::THR_W-1:0];
                pmd_pkg::REG_IDX_WGT: r_weight <= pwdata[pmd_pkg::WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[pmd_pkg::REG_IDX_LSB])
            pmd_pkg::REG_IDX_THR: prdata = pmd_pkg::PDATA_W'(r_thr);
            pmd_pkg::REG_IDX_WGT: prdata = pmd_pkg::PDATA_W'(r_weight);
            default:              prdata = '0;
        endcase
    end

    // sequencing
    assign w_in_acc     = i_in_valid && (r_state == S_IDLE);
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_root_start = (r_state == S_SQR) && sqr_sts.done;
    assign w_ema_start  = (r_state == S_ROOT) && root_sts.done;
    assign w_out_load   = (r_state == S_EMA) && ema_sts.done && w_out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_acc) n_state = S_SQR;
            S_SQR:  if (w_root_start) n_state = S_ROOT;
            S_ROOT: if (w_ema_start) n_state = S_EMA;
            S_EMA:  if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_metric    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_prev_x <= w_x;
                r_prev_y <= w_y;
            end
            if (w_out_load) begin
                r_metric    <= w_metric;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data.smoothed_metric <= w_metric;
            r_out_data.large_motion    <= w_flag;
        end
    end

    // step from the previous position
    assign w_x  = POS_BITS'(i_in_data.pos_x);
    assign w_y  = POS_BITS'(i_in_data.pos_y);
    assign w_dx = (w_x >= r_prev_x) ? (w_x - r_prev_x) : (r_prev_x - w_x);
    assign w_dy = (w_y >= r_prev_y) ? (w_y - r_prev_y) : (r_prev_y - w_y);

    pmd_smac #(
        .OPD_W (POS_BITS),
        .MUL_W (POS_BITS)
    ) u_sqr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_acc),
        .i_opd_a (w_dx),
        .i_opd_b (w_dy),
        .i_mul_a (w_dx),
        .i_mul_b (w_dy),
        .o_acc   (w_sum),
        .o_sts   (sqr_sts)
    );

    // length with FRAC_BITS fraction bits
    assign w_rad = RAD_W'({w_sum, {(2 * FRAC_BITS){1'b0}}});

    pmd_sqrt #(
        .ROOT_W (ROOT_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_root_start),
        .i_radicand (w_rad),
        .o_root     (w_root),
        .o_sts      (root_sts)
    );

    // weighted average of new length and stored metric
    assign w_alpha = (r_weight > pmd_pkg::WEIGHT_ONE) ? pmd_pkg::WEIGHT_ONE : r_weight;
    assign w_beta  = pmd_pkg::WEIGHT_ONE - w_alpha;

    pmd_smac #(
        .OPD_W (EMA_OPD_W),
        .MUL_W (pmd_pkg::WEIGHT_W)
    ) u_ema (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ema_start),
        .i_opd_a (EMA_OPD_W'(w_root)),
        .i_opd_b (EMA_OPD_W'(r_metric)),
        .i_mul_a (w_alpha),
        .i_mul_b (w_beta),
        .o_acc   (w_ema_acc),
        .o_sts   (ema_sts)
    );

    assign w_metric  = (|w_ema_acc[EMA_ACC_W-1:SAT_LSB]) ? pmd_pkg::METRIC_MAX
                     : w_ema_acc[pmd_pkg::WEIGHT_SHIFT +: pmd_pkg::METRIC_W];
    assign w_thr_cmp = CMP_W'(r_thr) << FRAC_BITS;
    assign w_flag    = CMP_W'(w_metric) > w_thr_cmp;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    a_flag_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> o_out_data.large_motion ==
            (CMP_W'(o_out_data.smoothed_metric) > $past(w_thr_cmp)))
        else $error("large_motion disagrees with loaded metric");

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({sqr_sts.busy, root_sts.busy, ema_sts.busy}))
        else $error("more than one serial unit busy");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !(sqr_sts.busy || root_sts.busy || ema_sts.busy))
        else $error("input open while a unit is busy");

    a_start_sqr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> sqr_sts.busy && !sqr_sts.done)
        else $error("accepted transaction did not start the sum of squares");
`endif

endmodule

// ===== verif/pointer_motion_ema_detector_check.sv =====
// checker for the pointer motion detector: tracks registers, predicts each result and compares
module pointer_motion_ema_detector_check (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  pmd_pkg::t_in_item            i_in_data,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  pmd_pkg::t_out_item           i_out_data,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic                         i_pready,
    input  logic [pmd_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [pmd_pkg::PDATA_W-1:0]  i_pwdata,
    output int                           o_fail_count,
    output int                           o_results_seen
);

    pmd_pkg::t_out_item              expected_motion[$];
    logic [pmd_pkg::POS_FIELD_W-1:0] last_x;
    logic [pmd_pkg::POS_FIELD_W-1:0] last_y;
    logic [pmd_pkg::METRIC_W-1:0]    smooth_metric;
    logic [pmd_pkg::THR_W-1:0]       threshold_px;
    logic [pmd_pkg::WEIGHT_W-1:0]    weight_q8;
    int                              mismatches = 0;
    int                              seen       = 0;

    // floor square root, one root bit per pass from the top
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    function automatic pmd_pkg::t_out_item motion_after_step(input pmd_pkg::t_in_item pos);
        logic [pmd_pkg::POS_FIELD_W-1:0] dx;
        logic [pmd_pkg::POS_FIELD_W-1:0] dy;
        logic [63:0]                     ex;
        logic [63:0]                     ey;
        logic [63:0]                     len;
        logic [63:0]                     alpha;
        logic [63:0]                     full_w;
        logic [63:0]                     old_m;
        logic [63:0]                     acc;
        logic [63:0]                     level;
        pmd_pkg::t_out_item              res;
        dx = (pos.pos_x >= last_x) ? pos.pos_x - last_x : last_x - pos.pos_x;
        dy = (pos.pos_y >= last_y) ? pos.pos_y - last_y : last_y - pos.pos_y;
        ex = dx;
        ey = dy;
        len = floor_sqrt((ex * ex + ey * ey) << (2 * pmd_pkg::FRAC_BITS_DEF));
        full_w = pmd_pkg::WEIGHT_ONE;
        alpha = weight_q8;
        if (alpha > full_w) alpha = full_w;
        old_m = smooth_metric;
        acc = (alpha * len + (full_w - alpha) * old_m) >> pmd_pkg::WEIGHT_SHIFT;
        if (acc > pmd_pkg::METRIC_MAX) acc = pmd_pkg::METRIC_MAX;
        level = threshold_px;
        level = level << pmd_pkg::FRAC_BITS_DEF;
        res.smoothed_metric = acc[pmd_pkg::METRIC_W-1:0];
        res.large_motion    = (acc > level);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        pmd_pkg::t_out_item want;
        if (!i_rst_n) begin
            expected_motion.delete();
            last_x        = '0;
            last_y        = '0;
            smooth_metric = '0;
            threshold_px  = pmd_pkg::THR_RESET;
            weight_q8     = pmd_pkg::WEIGHT_RESET;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[pmd_pkg::REG_IDX_LSB-1:0] == '0) begin
                if (i_paddr[pmd_pkg::REG_IDX_LSB] == pmd_pkg::REG_IDX_THR)
                    threshold_px = i_pwdata[pmd_pkg::THR_W-1:0];
                else
                    weight_q8 = i_pwdata[pmd_pkg::WEIGHT_W-1:0];
            end
            if (i_out_valid && !i_out_stall) begin
                seen++;
                if (expected_motion.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: metric %0d flag %0b",
                                 i_out_data.smoothed_metric, i_out_data.large_motion);
                    mismatches++;
                end else begin
                    want = expected_motion.pop_front();
                    if (i_out_data.smoothed_metric !== want.smoothed_metric ||
                        i_out_data.large_motion !== want.large_motion) begin
                        if (mismatches < 10)
                            $display({"mismatch: expected metric %0d flag %0b, ",
                                      "got metric %0d flag %0b"},
                                     want.smoothed_metric, want.large_motion,
                                     i_out_data.smoothed_metric, i_out_data.large_motion);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = motion_after_step(i_in_data);
                expected_motion.push_back(want);
                last_x        = i_in_data.pos_x;
                last_y        = i_in_data.pos_y;
                smooth_metric = want.smoothed_metric;
            end
        end
        o_fail_count   <= mismatches;
        o_results_seen <= seen;
    end

endmodule

// ===== verif/pointer_motion_ema_detector_test.sv =====
// testbench top for the pointer motion detector: clock, reset, stimulus and verdict
module pointer_motion_ema_detector_test;

    localparam int LATENCY_CYCLES = 2 * pmd_pkg::POS_BITS_DEF + pmd_pkg::FRAC_BITS_DEF + 13;
    localparam int POS_MAX        = (1 << pmd_pkg::POS_FIELD_W) - 1;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    pmd_pkg::t_in_item           in_data   = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    pmd_pkg::t_out_item          out_data;
    logic                        psel      = 1'b0;
    logic                        penable   = 1'b0;
    logic                        pwrite    = 1'b0;
    logic [pmd_pkg::PADDR_W-1:0] paddr     = '0;
    logic [pmd_pkg::PDATA_W-1:0] pwdata    = '0;
    logic [pmd_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    int fail_count;
    int results_seen;
    int items_sent  = 0;
    int tx_idle_pct = 37;
    int rx_idle_pct = 56;
    int cur_x       = 0;
    int cur_y       = 0;

    pointer_motion_ema_detector dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    pointer_motion_ema_detector_check check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_data     (out_data),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (fail_count),
        .o_results_seen (results_seen)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_position(input pmd_pkg::t_in_item pos);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= pos;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_xy(input int x, input int y);
        pmd_pkg::t_in_item pos;
        cur_x     = x;
        cur_y     = y;
        pos.pos_x = x[pmd_pkg::POS_FIELD_W-1:0];
        pos.pos_y = y[pmd_pkg::POS_FIELD_W-1:0];
        send_position(pos);
    endtask

    task automatic wait_for_results();
        while (results_seen < items_sent) @(posedge clk);
    endtask

    task automatic apb_write(input logic idx, input logic [pmd_pkg::PDATA_W-1:0] value);
        logic [pmd_pkg::PADDR_W-1:0] addr;
        addr = '0;
        addr[pmd_pkg::REG_IDX_LSB] = idx;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // registers change only with the block idle; upper data bits carry noise
    task automatic configure(input int thr, input int weight);
        logic [pmd_pkg::PDATA_W-1:0] word;
        in_valid <= 1'b0;
        wait_for_results();
        word = $urandom();
        word[pmd_pkg::THR_W-1:0] = thr[pmd_pkg::THR_W-1:0];
        apb_write(pmd_pkg::REG_IDX_THR, word);
        word = $urandom();
        word[pmd_pkg::WEIGHT_W-1:0] = weight[pmd_pkg::WEIGHT_W-1:0];
        apb_write(pmd_pkg::REG_IDX_WGT, word);
    endtask

    // mostly small pointer steps, some long moves, jumps and corners
    task automatic run_random(input int count);
        int r;
        int nx;
        int ny;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(79) == 0) begin
                in_valid <= 1'b0;
                wait_for_results();
            end
            r = $urandom_range(99);
            if (r < 55) begin
                nx = cur_x + int'($urandom_range(80)) - 40;
                ny = cur_y + int'($urandom_range(80)) - 40;
            end else if (r < 80) begin
                nx = cur_x + int'($urandom_range(6000)) - 3000;
                ny = cur_y + int'($urandom_range(6000)) - 3000;
            end else if (r < 93) begin
                nx = $urandom_range(POS_MAX);
                ny = $urandom_range(POS_MAX);
            end else begin
                nx = $urandom_range(1) ? POS_MAX : 0;
                ny = $urandom_range(1) ? POS_MAX : 0;
            end
            if (nx < 0) nx = 0;
            if (nx > POS_MAX) nx = POS_MAX;
            if (ny < 0) ny = 0;
            if (ny > POS_MAX) ny = POS_MAX;
            send_xy(nx, ny);
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the registers, first step measured from the origin
        send_xy(0, 0);
        send_xy(POS_MAX, POS_MAX);
        send_xy(0, 0);
        send_xy(POS_MAX, 0);
        send_xy(0, POS_MAX);
        send_xy(0, POS_MAX);
        send_xy(1, 0);
        send_xy(1, 1);
        send_xy(8191, 8192);
        send_xy(10, 10);

        // full weight, zero threshold: metric follows the length
        configure(0, 256);
        send_xy(POS_MAX, POS_MAX);
        send_xy(POS_MAX - 1, POS_MAX);
        send_xy(POS_MAX - 1, POS_MAX);

        // weight above one acts as one
        configure(32767, 511);
        send_xy(0, 0);
        send_xy(3, 4);
        configure(32767, 257);
        send_xy(0, 0);

        // zero weight holds the metric
        configure(0, 0);
        send_xy(POS_MAX, POS_MAX);
        send_xy(0, 0);

        configure(32767, 1);
        send_xy(POS_MAX, 0);
        send_xy(0, POS_MAX);

        configure(90, 205);
        run_random(175);
        configure(32767, 256);
        run_random(175);

        tx_idle_pct = 56;
        rx_idle_pct = 37;
        configure($urandom_range(300), $urandom_range(511));
        run_random(175);
        configure(0, 511);
        run_random(175);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        configure($urandom_range(32767), $urandom_range(511));
        run_random(175);
        configure(90, $urandom_range(255, 1));
        run_random(175);

        in_valid <= 1'b0;
        wait_for_results();
        repeat (LATENCY_CYCLES) @(posedge clk);
        if (fail_count == 0 && results_seen == items_sent) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/pmd_pkg.sv
design/pmd_smac.sv
design/pmd_sqrt.sv
design/pointer_motion_ema_detector.sv
verif/pointer_motion_ema_detector_check.sv
verif/pointer_motion_ema_detector_test.sv
